/* sv/md5_digest_engine_assert.svh */
// Assertion macros for the md5 digest engine, used by md5_ctrl.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef MD5_DIGEST_ENGINE_ASSERT_SVH
`define MD5_DIGEST_ENGINE_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define MDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be true outside reset
`define MDE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* sv/md5_pkg.sv */
// Package for the md5 digest engine: controller states, command and status
// structs, initial chaining values and the round constant, shift and index tables.
package md5_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FIN,
        S_PAD,
        S_LEN,
        S_OUT
    } t_state;

    // What follows a compression
    typedef enum logic [1:0] {
        A_IDLE,
        A_PAD,
        A_LEN,
        A_OUT
    } t_after;

    // Controller to datapath commands
    typedef struct packed {
        logic       absorb;
        logic       pad;
        logic       len_fill;
        logic       cmp_load;
        logic       cmp_round;
        logic       cmp_fin;
        logic       out_done;
        logic [5:0] round;
        logic [3:0] out_idx;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic wrap;     // next byte completes a block
        logic pad_two;  // padding spills into a second block
    } t_dp_sts;

    localparam logic [3:0][31:0] MD5_INIT = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Round additive constant
    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount, selected by round group and round index mod 4
    function automatic logic [4:0] md5_shift(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index for a round, all arithmetic mod 16
    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] lo;
        logic [3:0] g;
        lo = idx[3:0];
        case (idx[5:4])
            2'd0:    g = lo;
            2'd1:    g = lo + {lo[1:0], 2'b00} + 4'd1;
            2'd2:    g = lo + {lo[2:0], 1'b0} + 4'd5;
            2'd3:    g = {lo[0], 3'b000} - lo;
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

/* sv/md5_ctrl.sv */
// Controller for the md5 digest engine: sequences absorb, padding,
// compression rounds and digest output. Depends on md5_pkg.
module md5_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_has_byte,
    input  logic              i_end_of_message,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_digest_last,
    input  md5_pkg::t_dp_sts  i_sts,
    output md5_pkg::t_dp_cmd  o_cmd
);
    import md5_pkg::*;

    t_state     r_state, n_state;
    t_after     r_after, n_after;
    logic [5:0] r_round, n_round;
    logic [3:0] r_k, n_k;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= A_IDLE;
            r_round <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_round <= n_round;
            r_k     <= n_k;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_after       = r_after;
        n_round       = r_round;
        n_k           = r_k;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_digest_last = (r_k == 4'd15);
        o_cmd         = '0;
        o_cmd.round   = r_round;
        o_cmd.out_idx = r_k;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.absorb = 1'b1;
                    if (i_has_byte && i_sts.wrap) begin
                        n_state = S_LOAD;
                        n_after = i_end_of_message ? A_PAD : A_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                n_state   = S_LOAD;
                n_after   = i_sts.pad_two ? A_LEN : A_OUT;
            end
            S_LEN: begin
                o_cmd.len_fill = 1'b1;
                n_state        = S_LOAD;
                n_after        = A_OUT;
            end
            S_LOAD: begin
                o_cmd.cmp_load = 1'b1;
                n_round        = '0;
                n_state        = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.cmp_round = 1'b1;
                n_round         = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.cmp_fin = 1'b1;
                case (r_after)
                    A_IDLE:  n_state = S_IDLE;
                    A_PAD:   n_state = S_PAD;
                    A_LEN:   n_state = S_LEN;
                    A_OUT:   n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
                n_k = '0;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_k = r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        o_cmd.out_done = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`include "md5_digest_engine_assert.svh"

    `MDE_NEVER(a_ready_and_valid, o_in_ready && o_out_valid, "input taken during digest output")
    `MDE_ASSERT(a_rounds_end, (r_state == S_ROUND && r_round == 6'd63) |=> (r_state == S_FIN), "round count overran")
    `MDE_ASSERT(a_last_to_idle, (o_out_valid && i_out_ready && o_digest_last) |=> (r_state == S_IDLE), "no return to idle after last digest byte")
    `MDE_ASSERT(a_eom_pads, (o_in_ready && i_in_valid && i_end_of_message && !(i_has_byte && i_sts.wrap)) |=> (r_state == S_PAD), "end of message did not start padding")
    `MDE_ASSERT(a_fin_count, (r_state == S_FIN) |-> (r_round == 6'd0), "finalise without full round sweep")

endmodule

/* sv/md5_dp.sv */
// Datapath for the md5 digest engine: block store, byte count, chaining and
// working words, one MD5 round per cycle. Depends on md5_pkg.
module md5_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_byte_value,
    input  logic              i_has_byte,
    input  md5_pkg::t_dp_cmd  i_cmd,
    output md5_pkg::t_dp_sts  o_sts,
    output logic [7:0]        o_digest_byte
);
    import md5_pkg::*;

    logic [31:0] r_blk [16];
    logic [31:0] n_blk [16];
    logic [60:0] r_count, n_count;
    logic [3:0][31:0] r_chain, n_chain;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;

    logic [5:0]  w_pos;
    logic [31:0] w_len_lo, w_len_hi;
    logic [31:0] w_f, w_sum, w_rot;
    logic [63:0] w_dbl;
    logic [4:0]  w_s;

    assign w_pos    = r_count[5:0];
    assign w_len_lo = {r_count[28:0], 3'b000};
    assign w_len_hi = r_count[60:29];

    assign o_sts.wrap    = (w_pos == 6'd63);
    assign o_sts.pad_two = (w_pos >= 6'd56);

    // Digest byte, a0 low byte first
    assign o_digest_byte = r_chain[i_cmd.out_idx[3:2]][{i_cmd.out_idx[1:0], 3'b000} +: 8];

    // Round function
    always_comb begin
        case (i_cmd.round[5:4])
            2'd0:    w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    w_f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    w_f = r_b ^ r_c ^ r_d;
            2'd3:    w_f = r_c ^ (r_b | ~r_d);
            default: w_f = '0;
        endcase
        w_sum = w_f + r_a + md5_k(i_cmd.round) + r_blk[md5_g(i_cmd.round)];
        w_s   = md5_shift(i_cmd.round);
        w_dbl = {w_sum, w_sum} << w_s;
        w_rot = w_dbl[63:32];
    end

    // Block store, count and word updates
    always_comb begin
        n_blk   = r_blk;
        n_count = r_count;
        n_chain = r_chain;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        if (i_cmd.absorb && i_has_byte) begin
            if (w_pos[1:0] == 2'd0) begin
                n_blk[w_pos[5:2]] = {24'h0, i_byte_value};
            end else begin
                n_blk[w_pos[5:2]][{w_pos[1:0], 3'b000} +: 8] = i_byte_value;
            end
            n_count = r_count + 61'd1;
        end
        if (i_cmd.pad) begin
            if (w_pos[1:0] == 2'd0) begin
                n_blk[w_pos[5:2]] = {24'h0, PAD_BYTE};
            end else begin
                n_blk[w_pos[5:2]][{w_pos[1:0], 3'b000} +: 8] = PAD_BYTE;
            end
            for (int j = 0; j < 16; j++) begin
                if (4'(j) > w_pos[5:2]) begin
                    n_blk[4'(j)] = '0;
                end
            end
            if (!o_sts.pad_two) begin
                n_blk[14] = w_len_lo;
                n_blk[15] = w_len_hi;
            end
        end
        if (i_cmd.len_fill) begin
            for (int j = 0; j < 14; j++) begin
                n_blk[4'(j)] = '0;
            end
            n_blk[14] = w_len_lo;
            n_blk[15] = w_len_hi;
        end
        if (i_cmd.cmp_load) begin
            n_a = r_chain[0];
            n_b = r_chain[1];
            n_c = r_chain[2];
            n_d = r_chain[3];
        end
        if (i_cmd.cmp_round) begin
            n_a = r_d;
            n_d = r_c;
            n_c = r_b;
            n_b = r_b + w_rot;
        end
        if (i_cmd.cmp_fin) begin
            n_chain[0] = r_chain[0] + r_a;
            n_chain[1] = r_chain[1] + r_b;
            n_chain[2] = r_chain[2] + r_c;
            n_chain[3] = r_chain[3] + r_d;
        end
        if (i_cmd.out_done) begin
            n_chain = MD5_INIT;
            n_count = '0;
        end
    end

    // Block store holds no reset
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_chain <= MD5_INIT;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
        end else begin
            r_count <= n_count;
            r_chain <= n_chain;
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
        end
    end

endmodule

/* sv/md5_digest_engine.sv */
// Top level of the md5 digest engine: controller plus datapath.
// Depends on md5_pkg, md5_ctrl and md5_dp.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_byte_value, i_has_byte, i_end_of_message
//  out      output     o_out_valid / i_out_ready o_digest_byte, o_digest_last
//
// A byte that does not complete a block is taken in idle. A byte completing a
// 64-byte block starts a compression: chaining load, the rounds on the single
// round unit, then chaining add. End of message adds a padding step plus one or
// two such compressions, the second after a length fill, then 16 output transactions.
// Reset is synchronous and needs no clearing pass; the block store is not reset.
// Output backpressure holds the engine in digest output; input is refused
// while padding, compressing or emitting.
module md5_digest_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_value,
    input  logic       i_has_byte,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_digest_byte,
    output logic       o_digest_last
);
    import md5_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    md5_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_last    (o_digest_last),
        .i_sts            (w_sts),
        .o_cmd            (w_cmd)
    );

    md5_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_value  (i_byte_value),
        .i_has_byte    (i_has_byte),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_digest_byte (o_digest_byte)
    );

endmodule
